>>> sv/arm64_page_table_walker_top_macros.svh
// Assertion macros used by the walker checker
`ifndef ARM64_PAGE_TABLE_WALKER_TOP_MACROS_SVH
`define ARM64_PAGE_TABLE_WALKER_TOP_MACROS_SVH

// Clocked property with reset disable and a fixed message
`define APW_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("apw assertion failed");

// Same, with a caller message
`define APW_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> sv/apw_pkg.sv
// Package: types, codes and mask helpers for the page table walker
`timescale 1ns / 1ps

package apw_pkg;

    localparam int unsigned ADDR_W             = 48;
    localparam int unsigned VA_W               = 64;
    localparam int unsigned DATA_W             = 64;
    localparam int unsigned CFG_IDX_W          = 3;
    localparam int unsigned PHYS_ADDR_BITS_DEF = 48;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_DATA   = 1'b1;
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [2:0] SIZE_4K   = 3'd0;
    localparam logic [2:0] SIZE_64K  = 3'd1;
    localparam logic [2:0] SIZE_2M   = 3'd2;
    localparam logic [2:0] SIZE_512M = 3'd3;
    localparam logic [2:0] SIZE_1G   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [1:0] GRAN_4K  = 2'd0;
    localparam logic [1:0] GRAN_64K = 2'd1;

    localparam logic [1:0] DESC_TABLE = 2'b11;
    localparam logic [1:0] DESC_BLOCK = 2'b01;

    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;
    localparam logic [1:0] LVL_3 = 2'd3;

    // size offsets giving 39-bit and 42-bit regions
    localparam logic [5:0] SO_39 = 6'd25;
    localparam logic [5:0] SO_42 = 6'd22;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROOT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_GRAN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_GRAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_SO     = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] kernel_root;
        logic [1:0]        kernel_granule;
        logic [1:0]        user_granule;
        logic [5:0]        kernel_size_offset;
        logic [5:0]        user_size_offset;
    } cfg_t;

    typedef struct packed {
        logic            active;
        logic [1:0]      level;
        logic            big;
        logic [VA_W-1:0] vaddr;
    } walk_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [2:0]        page_size;
        logic [1:0]        status;
    } res_t;

    // bits lo .. pab-1 of a 48-bit address
    function automatic logic [ADDR_W-1:0] pa_mask(int unsigned pab, int unsigned lo);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int unsigned i = 0; i < ADDR_W; i++)
        begin
            m[i] = (i >= lo) && (i < pab);
        end
        return m;
    endfunction

endpackage

>>> sv/apw_step.sv
// One walk step: next walk state and result from a registered item
`timescale 1ns / 1ps

module apw_step #(
    parameter int unsigned PHYS_ADDR_BITS = apw_pkg::PHYS_ADDR_BITS_DEF
) (
    input  apw_pkg::cfg_t                   cfg,
    input  apw_pkg::walk_t                  walk,
    input  logic                            op,
    input  logic [apw_pkg::ADDR_W-1:0]      table_base,
    input  logic [apw_pkg::VA_W-1:0]        virt_addr,
    input  logic [apw_pkg::DATA_W-1:0]      read_data,
    output apw_pkg::walk_t                  walk_next,
    output logic                            res_valid,
    output apw_pkg::res_t                   res
);

    localparam logic [apw_pkg::ADDR_W-1:0] M9  = apw_pkg::pa_mask(PHYS_ADDR_BITS, 9);
    localparam logic [apw_pkg::ADDR_W-1:0] M12 = apw_pkg::pa_mask(PHYS_ADDR_BITS, 12);
    localparam logic [apw_pkg::ADDR_W-1:0] M16 = apw_pkg::pa_mask(PHYS_ADDR_BITS, 16);
    localparam logic [apw_pkg::ADDR_W-1:0] M21 = apw_pkg::pa_mask(PHYS_ADDR_BITS, 21);
    localparam logic [apw_pkg::ADDR_W-1:0] M29 = apw_pkg::pa_mask(PHYS_ADDR_BITS, 29);
    localparam logic [apw_pkg::ADDR_W-1:0] M30 = apw_pkg::pa_mask(PHYS_ADDR_BITS, 30);

    function automatic logic [apw_pkg::ADDR_W-1:0] read_addr(
        input logic [1:0]                  lvl,
        input logic [apw_pkg::ADDR_W-1:0]  base,
        input logic [apw_pkg::VA_W-1:0]    va,
        input logic                        big
    );
        logic [apw_pkg::ADDR_W-1:0] a;
        if (big)
        begin
            case (lvl)
                apw_pkg::LVL_1: a = (base & M9)  | {39'b0, va[47:42], 3'b0};
                apw_pkg::LVL_2: a = (base & M16) | {32'b0, va[41:29], 3'b0};
                default:        a = (base & M16) | {32'b0, va[28:16], 3'b0};
            endcase
        end
        else
        begin
            case (lvl)
                apw_pkg::LVL_0: a = (base & M12) | {36'b0, va[47:39], 3'b0};
                apw_pkg::LVL_1: a = (base & M12) | {36'b0, va[38:30], 3'b0};
                apw_pkg::LVL_2: a = (base & M12) | {36'b0, va[29:21], 3'b0};
                default:        a = (base & M12) | {36'b0, va[20:12], 3'b0};
            endcase
        end
        return a;
    endfunction

    logic                       kern;
    logic [1:0]                 gran;
    logic [5:0]                 so;
    logic [1:0]                 start_lvl;
    logic [1:0]                 desc_type;
    logic [apw_pkg::ADDR_W-1:0] desc_pa;
    logic [apw_pkg::ADDR_W-1:0] next_base;

    assign kern      = (table_base == cfg.kernel_root);
    assign gran      = kern ? cfg.kernel_granule : cfg.user_granule;
    assign so        = kern ? cfg.kernel_size_offset : cfg.user_size_offset;
    assign desc_type = read_data[1:0];
    assign desc_pa   = read_data[apw_pkg::ADDR_W-1:0];
    assign next_base = desc_pa & (walk.big ? M16 : M12);

    always_comb
    begin
        if (gran == apw_pkg::GRAN_64K)
            start_lvl = (so == apw_pkg::SO_42) ? apw_pkg::LVL_2 : apw_pkg::LVL_1;
        else
            start_lvl = (so == apw_pkg::SO_39) ? apw_pkg::LVL_1 : apw_pkg::LVL_0;
    end

    always_comb
    begin
        walk_next     = walk;
        res_valid     = 1'b0;
        res.kind      = apw_pkg::KIND_DONE;
        res.address   = '0;
        res.page_size = apw_pkg::SIZE_4K;
        res.status    = apw_pkg::ST_OK;
        if (op == apw_pkg::OP_START)
        begin
            res_valid        = 1'b1;
            walk_next.active = 1'b0;
            if (gran != apw_pkg::GRAN_4K && gran != apw_pkg::GRAN_64K)
            begin
                res.status = apw_pkg::ST_UNSUP;
            end
            else
            begin
                walk_next.active = 1'b1;
                walk_next.big    = (gran == apw_pkg::GRAN_64K);
                walk_next.vaddr  = virt_addr;
                walk_next.level  = start_lvl;
                res.kind         = apw_pkg::KIND_READ;
                res.address      = read_addr(start_lvl, table_base, virt_addr,
                                             gran == apw_pkg::GRAN_64K);
            end
        end
        else if (walk.active)
        begin
            res_valid = 1'b1;
            if (walk.level == apw_pkg::LVL_3)
            begin
                // last level: no validity check
                walk_next.active = 1'b0;
                if (walk.big)
                begin
                    res.address   = (desc_pa & M16) | {32'b0, walk.vaddr[15:0]};
                    res.page_size = apw_pkg::SIZE_64K;
                end
                else
                begin
                    res.address   = (desc_pa & M12) | {36'b0, walk.vaddr[11:0]};
                    res.page_size = apw_pkg::SIZE_4K;
                end
            end
            else if (desc_type == apw_pkg::DESC_TABLE)
            begin
                walk_next.level = walk.level + 2'd1;
                res.kind        = apw_pkg::KIND_READ;
                res.address     = read_addr(walk.level + 2'd1, next_base,
                                            walk.vaddr, walk.big);
            end
            else
            begin
                walk_next.active = 1'b0;
                res.status       = apw_pkg::ST_FAULT;
                if (desc_type == apw_pkg::DESC_BLOCK)
                begin
                    if (!walk.big && walk.level == apw_pkg::LVL_1)
                    begin
                        res.address   = (desc_pa & M30) | {18'b0, walk.vaddr[29:0]};
                        res.page_size = apw_pkg::SIZE_1G;
                        res.status    = apw_pkg::ST_OK;
                    end
                    else if (!walk.big && walk.level == apw_pkg::LVL_2)
                    begin
                        res.address   = (desc_pa & M21) | {27'b0, walk.vaddr[20:0]};
                        res.page_size = apw_pkg::SIZE_2M;
                        res.status    = apw_pkg::ST_OK;
                    end
                    else if (walk.big && walk.level == apw_pkg::LVL_2)
                    begin
                        res.address   = (desc_pa & M29) | {19'b0, walk.vaddr[28:0]};
                        res.page_size = apw_pkg::SIZE_512M;
                        res.status    = apw_pkg::ST_OK;
                    end
                end
            end
        end
    end

endmodule

>>> sv/arm64_page_table_walker_top.sv
// Page table walker top level: channel registers, walk state and configuration
//
// Request channel (req_valid/req_ready) carries one transaction per walk step:
// op 0 starts a walk from table_base/virt_addr, op 1 returns a descriptor in
// read_data. Each transaction yields at most one response on rsp_valid/rsp_ready:
// kind 0 asks for a descriptor read at address, kind 1 ends the walk with the
// physical address, page_size and status. A data transaction with no walk in
// progress yields no response; a start abandons any walk in progress.
// An accepted request waits in the input register until the step unit fires;
// one pass of step logic then loads its result into the response register.
// Throughput: one transaction per cycle, bounded by the single step unit, which
// advances whenever the response register is empty or being drained.
// When the receiver stalls, the response register holds and the input register
// still takes one more transaction before req_ready falls.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while the walker is idle. Unknown indexes are dropped.
// Reset clears the walk state, the valid flags of both channel registers and
// the configuration (size offsets reset to 16).
`timescale 1ns / 1ps

module arm64_page_table_walker_top #(
    parameter int unsigned PHYS_ADDR_BITS = apw_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              op,
    input  logic [apw_pkg::ADDR_W-1:0]        table_base,
    input  logic [apw_pkg::VA_W-1:0]          virt_addr,
    input  logic [apw_pkg::DATA_W-1:0]        read_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              kind,
    output logic [apw_pkg::ADDR_W-1:0]        address,
    output logic [2:0]                        page_size,
    output logic [1:0]                        status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [apw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apw_pkg::ADDR_W-1:0]        cfg_data
);

    apw_pkg::cfg_t  cfg_reg;
    apw_pkg::walk_t walk_reg;
    apw_pkg::walk_t walk_next;
    apw_pkg::res_t  res_next;
    apw_pkg::res_t  rsp_reg;
    logic           res_valid;

    logic                       full_reg;
    logic                       op_reg;
    logic [apw_pkg::ADDR_W-1:0] base_reg;
    logic [apw_pkg::VA_W-1:0]   va_reg;
    logic [apw_pkg::DATA_W-1:0] data_reg;
    logic                       rsp_valid_reg;
    logic                       fire;
    logic                       req_take;

    assign fire      = full_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !full_reg || fire;
    assign req_take  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_root        <= '0;
            cfg_reg.kernel_granule     <= apw_pkg::GRAN_4K;
            cfg_reg.user_granule       <= apw_pkg::GRAN_4K;
            cfg_reg.kernel_size_offset <= 6'd16;
            cfg_reg.user_size_offset   <= 6'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                apw_pkg::CFG_KERNEL_ROOT: cfg_reg.kernel_root        <= cfg_data;
                apw_pkg::CFG_KERNEL_GRAN: cfg_reg.kernel_granule     <= cfg_data[1:0];
                apw_pkg::CFG_USER_GRAN:   cfg_reg.user_granule       <= cfg_data[1:0];
                apw_pkg::CFG_KERNEL_SO:   cfg_reg.kernel_size_offset <= cfg_data[5:0];
                apw_pkg::CFG_USER_SO:     cfg_reg.user_size_offset   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // hold the accepted transaction until the step unit takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (req_ready)
            full_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg   <= op;
            base_reg <= table_base;
            va_reg   <= virt_addr;
            data_reg <= read_data;
        end
    end

    apw_step #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_step (
        .cfg        (cfg_reg),
        .walk       (walk_reg),
        .op         (op_reg),
        .table_base (base_reg),
        .virt_addr  (va_reg),
        .read_data  (data_reg),
        .walk_next  (walk_next),
        .res_valid  (res_valid),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walk_reg <= '0;
        else if (fire)
            walk_reg <= walk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (fire && res_valid)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
            rsp_reg <= res_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign kind      = rsp_reg.kind;
    assign address   = rsp_reg.address;
    assign page_size = rsp_reg.page_size;
    assign status    = rsp_reg.status;

endmodule

>>> sv/apw_checker.sv
// Port-level checker for the page table walker, bound to the top level
`timescale 1ns / 1ps
`include "arm64_page_table_walker_top_macros.svh"

module apw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         kind,
    input logic [apw_pkg::ADDR_W-1:0]   address,
    input logic [2:0]                   page_size,
    input logic [1:0]                   status
);

    `APW_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid)
    `APW_ASSERT_MSG(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready |=> $stable(address) && $stable(kind) && $stable(page_size) && $stable(status), "stalled response changed")
    `APW_ASSERT_MSG(a_read_plain, clk, rst_n, rsp_valid && kind == apw_pkg::KIND_READ |-> page_size == apw_pkg::SIZE_4K && status == apw_pkg::ST_OK, "read request with size or status")
    `APW_ASSERT_MSG(a_err_clean, clk, rst_n, rsp_valid && status != apw_pkg::ST_OK |-> kind == apw_pkg::KIND_DONE && address == '0 && page_size == apw_pkg::SIZE_4K, "error response not clean")

endmodule

bind arm64_page_table_walker_top apw_checker u_apw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .kind      (kind),
    .address   (address),
    .page_size (page_size),
    .status    (status)
);
